>>> rtl/tma_pkg.sv
// tma_pkg: constants, widths and state type for the thermal moving average
// depends on nothing; imported by temp_moving_average_top
package tma_pkg;

  // window depth is kept a power of two so the average is a plain shift
  localparam int WINDOW_DEPTH = 256;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);

  localparam int SAMPLE_W = 18;
  localparam int AVG_W    = 18;
  localparam int F_W      = 18;
  localparam int SUM_W    = F_W + PTR_W;
  localparam int NINE_W   = 20;
  localparam int MAG_W    = 17;

  localparam logic [MAG_W-1:0] LIMIT_MILLIC  = MAG_W'(85000);
  localparam logic [F_W-1:0]   OFFSET_MILLIF = F_W'(32000);

  // floor(x / 5) = (x * ceil(2^22 / 5)) >> 22 for every x below 2^22
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_DIV5 = RECIP_W'((1 << RECIP_SHIFT) / 5 + 1);
  localparam int PROD_W      = NINE_W + RECIP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_UPD
  } tma_state_t;

endpackage

>>> rtl/temp_moving_average_top.sv
// temp_moving_average_top: boxcar average of thermal readings, converted to
// milli-degrees fahrenheit, window held in a one-port-read/one-port-write ram
// depends on tma_pkg
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid in_ready in_sample_millic | in
//   out     | out_valid out_ready out_avg_millif | out
//
// a reading in range passes accept (ram read of the oldest entry), then the
// divide-by-5 multiply, then sum update and ram write-back, where the next
// beat is accepted; the ram read-then-write keeps out a new reading until then
// out-of-range readings are accepted and dropped and give no beat
// no clearing pass after reset: until the write pointer first wraps, unwritten
// entries read as the first converted reading
// a full output register stalls the update stage and the input
module temp_moving_average_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tma_pkg::SAMPLE_W-1:0]  in_sample_millic,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [tma_pkg::AVG_W-1:0]     out_avg_millif
);
  import tma_pkg::*;

  logic [F_W-1:0]    mem [WINDOW_DEPTH];
  logic [F_W-1:0]    rd_data_r;

  tma_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              awaiting_first_r, awaiting_first_nxt;
  logic              fill_done_r, fill_done_nxt;
  logic [F_W-1:0]    first_f_r, first_f_nxt;
  logic [NINE_W-1:0] nine_r;
  logic [F_W-1:0]    quo_r;
  logic              out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]  out_avg_r, out_avg_nxt;

  logic [MAG_W-1:0]  mag;
  logic              in_ok;
  logic              in_acc;
  logic              can_finish;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PROD_W-1:0] prod;
  logic [F_W-1:0]    f_val;
  logic [F_W-1:0]    old_val;

  // range check; the 9x by shift-add is in the payload registers
  assign mag   = in_sample_millic[MAG_W-1:0];
  assign in_ok = !in_sample_millic[SAMPLE_W-1] && (mag != '0) && (mag < LIMIT_MILLIC);

  assign can_finish = !out_valid_r || out_ready;
  assign in_acc     = in_valid && in_ready;

  assign prod    = PROD_W'(nine_r) * PROD_W'(RECIP_DIV5);
  assign f_val   = quo_r + OFFSET_MILLIF;
  assign old_val = fill_done_r ? rd_data_r : first_f_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ok) state_nxt = S_CONV;
      end
      S_CONV: state_nxt = S_UPD;
      S_UPD: begin
        if (can_finish) begin
          if (in_acc && in_ok) state_nxt = S_CONV;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CONV: in_ready = 1'b0;
      S_UPD: begin
        in_ready = can_finish;
        wr_en    = can_finish;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign rd_en   = in_acc && in_ok;
  assign rd_addr = wr_en ? ptr_r + PTR_W'(1) : ptr_r;

  always_comb begin
    ptr_nxt            = ptr_r;
    sum_nxt            = sum_r;
    awaiting_first_nxt = awaiting_first_r;
    fill_done_nxt      = fill_done_r;
    first_f_nxt        = first_f_r;
    out_avg_nxt        = out_avg_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    if (wr_en) begin
      if (awaiting_first_r) begin
        // window preloaded with this reading: total is depth times it
        sum_nxt            = {f_val, PTR_W'(0)};
        first_f_nxt        = f_val;
        awaiting_first_nxt = 1'b0;
      end else begin
        sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(f_val);
      end
      ptr_nxt = ptr_r + PTR_W'(1);
      if (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) fill_done_nxt = 1'b1;
      out_avg_nxt   = sum_nxt[SUM_W-1:PTR_W];
      out_valid_nxt = 1'b1;
    end
  end

  // window ram
  always_ff @(posedge clk) begin
    if (wr_en) mem[ptr_r] <= f_val;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_en) nine_r <= {mag, 3'b000} + NINE_W'(mag);
    if (state_r == S_CONV) quo_r <= prod[RECIP_SHIFT +: F_W];
    first_f_r <= first_f_nxt;
    out_avg_r <= out_avg_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      ptr_r            <= '0;
      sum_r            <= '0;
      awaiting_first_r <= 1'b1;
      fill_done_r      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      ptr_r            <= ptr_nxt;
      sum_r            <= sum_nxt;
      awaiting_first_r <= awaiting_first_nxt;
      fill_done_r      <= fill_done_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_millif = out_avg_r;

endmodule
